@@ rtl/core/bastc_pkg.sv @@
// Shared types and constants for the block average step counter.
// Holds the request payload structs, register index codes and sizing constants.
// No dependencies; every module of the block imports this package.
package bastc_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_BITS = 14;
    localparam int THR_BITS    = 14;
    localparam int COUNT_BITS  = 16;
    localparam int FILL_BITS   = 6;

    // Default number of samples in one averaging window (range 2 to 63).
    localparam int WINDOW_LEN_DEF = 50;

    // Shift-add multiplier for mean * fill: one multiplier bit per cycle.
    localparam int MUL_W = SAMPLE_BITS + FILL_BITS;

    // Shared divider: the numerator covers both 100 * 65535 and mean * 63 + x.
    localparam int DIV_NUM_W = 23;
    localparam int DIV_DEN_W = 16;

    localparam int unsigned JOY_UP_LEVEL   = 32'd16000;
    localparam int unsigned JOY_DOWN_LEVEL = 32'd1000;
    localparam int unsigned PERCENT_SCALE  = 32'd100;
    localparam logic [COUNT_BITS-1:0] SAT16 = '1;

    localparam logic [THR_BITS-1:0] THR_RESET = 14'd8192;

    typedef enum logic [0:0] {
        CMD_ACCEL    = 1'b0,
        CMD_JOYSTICK = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_STEP_THRESHOLD     = 2'd0,
        CFG_COUNT_ENABLE       = 2'd1,
        CFG_GOAL_ADJUST_ENABLE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                   command;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0] step_total;
        logic [COUNT_BITS-1:0] goal_now;
        logic [COUNT_BITS-1:0] percent_done;
        logic                  goal_reached;
        logic                  step_event;
    } t_out_item;

    // Handshake between the sequencer and the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/core/block_average_step_counter_core.sv @@
// Top level of the block average step counter: request channels, sequencer and state.
// Depends on bastc_pkg and instantiates the shared serial divider bastc_div.
//
// Usage. Each input request carries a command and a 14-bit converter sample.
// An accelerometer sample (command 0) updates a running mean over a window of
// WINDOW_LEN samples; when a window closes and its mean falls from above the
// step threshold to below it, one step is counted. A joystick sample (command 1)
// raises the goal when above 16000 and lowers it when below 1000, never below zero.
// Every request returns exactly one result with the step total, the goal, the
// percent of goal, the sticky goal-reached flag and a step event bit.
// The configuration channel writes the threshold and the two enables; it is
// always ready and should be used only while no request is in flight.
// Timing. The input channel is ready only while the sequencer is idle, which is
// from the cycle in which a result appears in the output register. An enabled
// accelerometer sample other than the first passes through the multiply steps,
// a divider start, the divide up to its done flag and the output step. When it
// counts a step the percent is recomputed with a second start and divide, which
// is skipped when the goal is zero. An enabled joystick sample above 16000 or
// below 1000 that leaves a nonzero goal also gets a percent divide; any other request needs no divide.
// The result sits in an output register, so the next request is accepted while
// a result waits; a stalled receiver holds the sequencer only at its last step.
// Reset is synchronous and restores the threshold to 8192, counting enabled,
// goal adjust disabled, and clears steps, goal and flags.
module block_average_step_counter_core
    import bastc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [THR_BITS-1:0] i_cfg_data
);

    localparam logic [FILL_BITS-1:0] WIN_END = FILL_BITS'(WINDOW_LEN);
    localparam int MUL_CNT_W = $clog2(FILL_BITS + 1);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(FILL_BITS - 1);

    // One-hot sequencer states.
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_JOY    = 8'b0000_0010,
        ST_MUL    = 8'b0000_0100,
        ST_MSTART = 8'b0000_1000,
        ST_MDIV   = 8'b0001_0000,
        ST_PSTART = 8'b0010_0000,
        ST_PDIV   = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [THR_BITS-1:0] r_thr;
    logic                r_count_en;
    logic                r_goal_en;

    // Detector and goal state.
    logic                   r_first, n_first;
    logic [SAMPLE_BITS-1:0] r_mean, n_mean;
    logic [SAMPLE_BITS-1:0] r_prev, n_prev;
    logic [FILL_BITS-1:0]   r_fill, n_fill;
    logic [COUNT_BITS-1:0]  r_steps, n_steps;
    logic [COUNT_BITS-1:0]  r_goal, n_goal;
    logic                   r_reached, n_reached;
    logic [COUNT_BITS-1:0]  r_pct, n_pct;
    logic                   r_event, n_event;

    // Latched request sample and multiplier datapath.
    logic [SAMPLE_BITS-1:0] r_x, n_x;
    logic [MUL_W-1:0]       r_acc, n_acc;
    logic [MUL_W-1:0]       r_mcand, n_mcand;
    logic [FILL_BITS-1:0]   r_mplier, n_mplier;
    logic [MUL_CNT_W-1:0]   r_mcnt, n_mcnt;

    // Output register.
    logic      r_ovalid, n_ovalid;
    t_out_item r_odata, n_odata;

    // Divider interface.
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    t_div_stat            div_stat;
    logic [DIV_NUM_W-1:0] div_quot;

    logic                   in_fire;
    logic [FILL_BITS-1:0]   fill_inc;
    logic [SAMPLE_BITS-1:0] new_mean;
    logic                   crossed;
    logic                   joy_up;
    logic                   joy_down;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;

    assign fill_inc = r_fill + 1'b1;
    assign new_mean = div_quot[SAMPLE_BITS-1:0];
    // A mean equal to the threshold is neither above nor below it.
    assign crossed  = (new_mean < r_thr) && (r_prev > r_thr);
    assign joy_up   = 32'(r_x) > JOY_UP_LEVEL;
    assign joy_down = 32'(r_x) < JOY_DOWN_LEVEL;

    // The divider is shared: mean update while in the mean phase, percent otherwise.
    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_NUM_W'(r_steps) * DIV_NUM_W'(PERCENT_SCALE);
        div_den   = r_goal;
        if (r_state == ST_MSTART) begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(r_acc) + DIV_NUM_W'(r_x);
            div_den   = DIV_DEN_W'(fill_inc);
        end else if (r_state == ST_PSTART) begin
            div_start = (r_goal != '0);
        end
    end

    bastc_div #(
        .NUM_W(DIV_NUM_W),
        .DEN_W(DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state   = r_state;
        n_first   = r_first;
        n_mean    = r_mean;
        n_prev    = r_prev;
        n_fill    = r_fill;
        n_steps   = r_steps;
        n_goal    = r_goal;
        n_reached = r_reached;
        n_pct     = r_pct;
        n_event   = r_event;
        n_x       = r_x;
        n_acc     = r_acc;
        n_mcand   = r_mcand;
        n_mplier  = r_mplier;
        n_mcnt    = r_mcnt;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;

        // The receiver may take the waiting result in any state.
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_x     = i_in_data.sample;
                    n_event = 1'b0;
                    if (i_in_data.command == CMD_ACCEL) begin
                        if (!r_count_en) begin
                            n_state = ST_FIN;
                        end else if (!r_first) begin
                            // The first sample seeds both means; the fill count stays.
                            n_first = 1'b1;
                            n_mean  = i_in_data.sample;
                            n_prev  = i_in_data.sample;
                            n_state = ST_FIN;
                        end else begin
                            n_acc    = '0;
                            n_mcand  = MUL_W'(r_mean);
                            n_mplier = r_fill;
                            n_mcnt   = '0;
                            n_state  = ST_MUL;
                        end
                    end else begin
                        n_state = r_goal_en ? ST_JOY : ST_FIN;
                    end
                end
            end
            ST_JOY: begin
                if (joy_up || joy_down) begin
                    if (joy_up) begin
                        if (r_goal != SAT16) begin
                            n_goal = r_goal + 1'b1;
                        end
                    end else if (r_goal != '0) begin
                        n_goal = r_goal - 1'b1;
                    end
                    if ((n_goal != '0) && (r_steps >= n_goal)) begin
                        n_reached = 1'b1;
                    end
                    n_state = ST_PSTART;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[MUL_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[FILL_BITS-1:1]};
                n_mcnt   = r_mcnt + 1'b1;
                if (r_mcnt == MUL_LAST) begin
                    n_state = ST_MSTART;
                end
            end
            ST_MSTART: begin
                n_state = ST_MDIV;
            end
            ST_MDIV: begin
                if (div_stat.done) begin
                    n_mean  = new_mean;
                    n_fill  = fill_inc;
                    n_state = ST_FIN;
                    if (fill_inc == WIN_END) begin
                        // Window closes: compare, then restart from this sample.
                        n_fill = FILL_BITS'(1);
                        n_prev = new_mean;
                        n_mean = r_x;
                        if (crossed) begin
                            if (r_steps != SAT16) begin
                                n_steps = r_steps + 1'b1;
                            end
                            n_event = 1'b1;
                            if ((r_goal != '0) && (n_steps >= r_goal)) begin
                                n_reached = 1'b1;
                            end
                            n_state = ST_PSTART;
                        end
                    end
                end
            end
            ST_PSTART: begin
                if (r_goal == '0) begin
                    n_pct   = '0;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (div_stat.done) begin
                    if (div_quot > DIV_NUM_W'(SAT16)) begin
                        n_pct = SAT16;
                    end else begin
                        n_pct = div_quot[COUNT_BITS-1:0];
                    end
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid              = 1'b1;
                    n_odata.step_total    = r_steps;
                    n_odata.goal_now      = r_goal;
                    n_odata.percent_done  = r_pct;
                    n_odata.goal_reached  = r_reached;
                    n_odata.step_event    = r_event;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_thr      <= THR_RESET;
            r_count_en <= 1'b1;
            r_goal_en  <= 1'b0;
            r_first    <= 1'b0;
            r_mean     <= '0;
            r_prev     <= '0;
            r_fill     <= FILL_BITS'(1);
            r_steps    <= '0;
            r_goal     <= '0;
            r_reached  <= 1'b0;
            r_pct      <= '0;
            r_event    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_first   <= n_first;
            r_mean    <= n_mean;
            r_prev    <= n_prev;
            r_fill    <= n_fill;
            r_steps   <= n_steps;
            r_goal    <= n_goal;
            r_reached <= n_reached;
            r_pct     <= n_pct;
            r_event   <= n_event;
            r_ovalid  <= n_ovalid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STEP_THRESHOLD:     r_thr      <= i_cfg_data;
                    CFG_COUNT_ENABLE:       r_count_en <= i_cfg_data[0];
                    CFG_GOAL_ADJUST_ENABLE: r_goal_en  <= i_cfg_data[0];
                    default: begin
                        // Writes to an unused index are dropped.
                    end
                endcase
            end
        end
        r_x      <= n_x;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_mcnt   <= n_mcnt;
        r_odata  <= n_odata;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

@@ rtl/core/bastc_div.sv @@
// Bit-serial restoring divider shared by the mean update and the percent calculation.
// Produces one quotient bit per cycle; depends on bastc_pkg for the status struct.
module bastc_div
    import bastc_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;

    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so DEN_W bits hold it.
            if (!diff[DEN_W+1]) begin
                n_rem = diff[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_CNT) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule
